>>> rtl/xy2tx_pkg.sv
// Shared types, constants and frame helper for the XY2-100 transmitter.
// Used by xy2tx_cell and galvo_xy2_100_transmitter_top.
package xy2tx_pkg;

    localparam int FRAME_BITS_DEF = 20;
    localparam int DATA_W         = 16;
    localparam logic [FRAME_BITS_DEF-1:0] IDLE_FRAME = 20'h20000;

    // Controls broadcast to every cell of the chain
    typedef struct packed {
        logic wr_en;     // write back buffer
        logic wr_sel;    // buffer index to write
        logic shift_en;  // advance the frame one bit toward the output
        logic load_en;   // reload the shift bits from a buffer
        logic load_sel;  // buffer index to reload from
    } cell_ctrl_t;

    // 0, 0, 1, data msb first, even parity over data
    function automatic logic [FRAME_BITS_DEF-1:0] make_frame(input logic [DATA_W-1:0] d);
        make_frame = {3'b001, d, ^d};
    endfunction

endpackage

>>> rtl/xy2tx_cell.sv
// One frame bit position of the transmitter: double-buffered X/Y bits and shift bits.
// Depends on xy2tx_pkg.
module xy2tx_cell #(
    parameter logic IDLE_BIT = 1'b0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  xy2tx_pkg::cell_ctrl_t ctrl,
    input  logic                  wr_x,
    input  logic                  wr_y,
    input  logic                  shift_in_x,
    input  logic                  shift_in_y,
    output logic                  shift_x,
    output logic                  shift_y
);
    import xy2tx_pkg::*;

    logic [1:0] store_x_reg;
    logic [1:0] store_y_reg;
    logic       shift_x_reg;
    logic       shift_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_x_reg <= {2{IDLE_BIT}};
            store_y_reg <= {2{IDLE_BIT}};
        end
        else if (ctrl.wr_en)
        begin
            store_x_reg[ctrl.wr_sel] <= wr_x;
            store_y_reg[ctrl.wr_sel] <= wr_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_x_reg <= IDLE_BIT;
            shift_y_reg <= IDLE_BIT;
        end
        else if (ctrl.load_en)
        begin
            shift_x_reg <= store_x_reg[ctrl.load_sel];
            shift_y_reg <= store_y_reg[ctrl.load_sel];
        end
        else if (ctrl.shift_en)
        begin
            shift_x_reg <= shift_in_x;
            shift_y_reg <= shift_in_y;
        end
    end

    assign shift_x = shift_x_reg;
    assign shift_y = shift_y_reg;

endmodule

>>> rtl/galvo_xy2_100_transmitter_top.sv
// XY2-100 galvo frame transmitter: a chain of bit cells shifting frames out.
// A tick word's output word is registered and shows on the output in the cycle after it is accepted.
// Throughput: one input word per cycle while the output is not stalled; set-position words produce no output.
// The output register frees in the same cycle it is taken, so a stalled output blocks input.
// Reset (async, rst_n low): idle frame in both buffers, update pending, clock phase high next.
// Depends on xy2tx_pkg and xy2tx_cell.
module galvo_xy2_100_transmitter_top #(
    parameter int FRAME_BITS = xy2tx_pkg::FRAME_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // x_position [15:0], y_position [31:16]
    input  logic        s_tuser,   // op: 0 tick, 1 set position
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // clock_level, sync_level, x_data_level, y_data_level, zeros
    output logic        m_tlast    // frame_end
);
    import xy2tx_pkg::*;

    localparam int POS_W = $clog2(FRAME_BITS);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BITS - 1);

    logic                  accept;
    logic                  tick;
    logic                  high_tick;
    logic                  at_last;
    cell_ctrl_t            ctrl;
    logic [FRAME_BITS-1:0] x_frame;
    logic [FRAME_BITS-1:0] y_frame;
    logic [FRAME_BITS:0]   chain_x;
    logic [FRAME_BITS:0]   chain_y;

    logic                  phase_reg,   phase_next;
    logic [POS_W-1:0]      pos_reg,     pos_next;
    logic                  front_reg,   front_next;
    logic                  pending_reg, pending_next;
    logic [2:0]            held_reg,    held_next;
    logic                  valid_reg,   valid_next;
    logic [3:0]            data_reg,    data_next;
    logic                  last_reg,    last_next;

    assign s_tready  = !valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign tick      = accept && !s_tuser;
    assign high_tick = tick && phase_reg;
    assign at_last   = (pos_reg >= LAST_POS);

    assign x_frame = FRAME_BITS'(make_frame(s_tdata[15:0]));
    assign y_frame = FRAME_BITS'(make_frame(s_tdata[31:16]));

    always_comb
    begin
        ctrl.wr_en    = accept && s_tuser;
        ctrl.wr_sel   = !front_reg;
        ctrl.shift_en = high_tick && !at_last;
        ctrl.load_en  = high_tick && at_last;
        ctrl.load_sel = front_reg ^ pending_reg;
    end

    // Cell 0 holds the bit on the wire; the far end fills with zeros
    assign chain_x[FRAME_BITS] = 1'b0;
    assign chain_y[FRAME_BITS] = 1'b0;

    for (genvar i = 0; i < FRAME_BITS; i++)
    begin : g_cell
        xy2tx_cell #(
            .IDLE_BIT (IDLE_FRAME[FRAME_BITS-1-i])
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .wr_x       (x_frame[FRAME_BITS-1-i]),
            .wr_y       (y_frame[FRAME_BITS-1-i]),
            .shift_in_x (chain_x[i+1]),
            .shift_in_y (chain_y[i+1]),
            .shift_x    (chain_x[i]),
            .shift_y    (chain_y[i])
        );
    end

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        front_next   = front_reg;
        pending_next = pending_reg;
        held_next    = held_reg;
        valid_next   = valid_reg && !m_tready;
        data_next    = data_reg;
        last_next    = last_reg;
        if (ctrl.wr_en)
        begin
            pending_next = 1'b1;
        end
        if (tick)
        begin
            phase_next = !phase_reg;
            valid_next = 1'b1;
            if (phase_reg)
            begin
                held_next = {!at_last, chain_x[0], chain_y[0]};
                data_next = {chain_y[0], chain_x[0], !at_last, 1'b1};
                last_next = at_last;
                if (at_last)
                begin
                    pos_next     = '0;
                    front_next   = front_reg ^ pending_reg;
                    pending_next = 1'b0;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            else
            begin
                // low phase: drop the clock, hold sync and data
                data_next = {held_reg[0], held_reg[1], held_reg[2], 1'b0};
                last_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= 1'b1;
            pos_reg     <= '0;
            front_reg   <= 1'b0;
            pending_reg <= 1'b1;
            held_reg    <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            front_reg   <= front_next;
            pending_reg <= pending_next;
            held_reg    <= held_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'b0000, data_reg};
    assign m_tlast  = last_reg;

endmodule

>>> rtl/xy2tx_checker.sv
// Port-level checks for the XY2-100 transmitter, bound to the top level.
// Depends on xy2tx_pkg only through the bound top level.
module xy2tx_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // frame end only with the clock high
    a_end_on_high: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[0])
        else $error("frame end without clock high");

    // on a high phase sync is low exactly at frame end
    a_sync_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> (m_tlast == !m_tdata[1]))
        else $error("sync and frame end disagree");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:4] == 4'b0000))
        else $error("padding bits not zero");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output word changed");

endmodule

bind galvo_xy2_100_transmitter_top xy2tx_checker u_xy2tx_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
